// ===== design/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int NUM_TIMERS_DEF = 8;

	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_INSTALL = 3'd1;
	localparam logic [2:0] KIND_RUN     = 3'd2;
	localparam logic [2:0] KIND_STOP    = 3'd3;
	localparam logic [2:0] KIND_DELETE  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  timer_id;
		logic [31:0] interval_ticks;
	} ptb_cmd_item_t;

	typedef struct packed {
		logic [7:0] fired_mask;
		logic       install_ok;
		logic [2:0] install_slot;
	} ptb_rsp_item_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ptb_ctl_t;

	typedef struct packed {
		logic last;
	} ptb_sts_t;

endpackage

// ===== design/periodic_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timers: install, run, stop, delete and tick operations.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  cmd     | in  | cmd_valid / stall | ptb_cmd_item_t (kind, timer_id, interval_ticks)
//  rsp     | out | rsp_valid / stall | ptb_rsp_item_t (fired_mask, install_ok, install_slot)
//
//  Tick: after accept, EXEC walks the table one slot of the table per cycle, then OUT
//  presents the result and holds it while rsp_stall is high.
//  Install, run, stop, delete and unknown kinds: after accept, pass through EXEC once, then OUT presents the result.
//  One item in flight; cmd_stall is high from accept until the result is taken.
//  rsp_stall holds the result; reset clears all slots to free and stopped.
// ----------------------------------------------------------------------------
module periodic_timer_bank #(
	parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  ptb_pkg::ptb_cmd_item_t cmd,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output ptb_pkg::ptb_rsp_item_t rsp
);
	import ptb_pkg::*;

	ptb_ctl_t ctl;
	ptb_sts_t sts;

	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	ptb_datapath #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule

// ===== design/ptb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer: accept an item, run it through the datapath, present the result.
// ----------------------------------------------------------------------------
module ptb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ptb_pkg::ptb_ctl_t ctl,
	input  ptb_pkg::ptb_sts_t sts
);
	import ptb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_OUT  = 3'b100
	} ptb_state_t;

	ptb_state_t state_q;
	ptb_state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.last) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!rsp_stall) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = (state_q == ST_OUT);
	assign ctl.load  = (state_q == ST_IDLE) && cmd_valid;
	assign ctl.exec  = (state_q == ST_EXEC);

endmodule

// ===== design/ptb_datapath.sv =====
// ----------------------------------------------------------------------------
// ptb_datapath
// Slot table and result registers; a tick walks one slot per cycle.
// ----------------------------------------------------------------------------
module ptb_datapath #(
	parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptb_pkg::ptb_cmd_item_t cmd,
	output ptb_pkg::ptb_rsp_item_t rsp,
	input  ptb_pkg::ptb_ctl_t      ctl,
	output ptb_pkg::ptb_sts_t      sts
);
	import ptb_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int FW = (NUM_TIMERS > 8) ? NUM_TIMERS : 8;
	localparam int SW = (IW > 3) ? IW : 3;

	logic [NUM_TIMERS-1:0] used_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [31:0]           count_q [NUM_TIMERS];
	logic [31:0]           period_q [NUM_TIMERS];
	logic [IW-1:0]         idx_q;

	logic [2:0]  kind_q;
	logic [3:0]  id_q;
	logic [31:0] ival_q;

	logic [FW-1:0] fire_q;
	logic          ok_q;
	logic [IW-1:0] slot_q;

	logic          free_found;
	logic [IW-1:0] free_idx;
	logic          id_ok;
	logic [IW-1:0] id_idx;
	logic [31:0]   cnt_inc;
	logic          hit;
	logic          idx_last;
	logic [SW-1:0] slot_ext;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign id_ok    = ({1'b0, id_q} < 5'(NUM_TIMERS));
	assign id_idx   = IW'(id_q);
	assign cnt_inc  = count_q[idx_q] + 32'd1;
	assign hit      = (cnt_inc >= period_q[idx_q]);
	assign idx_last = (idx_q == IW'(NUM_TIMERS - 1));
	assign sts.last = (kind_q != KIND_TICK) || idx_last;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			running_q <= '0;
			idx_q     <= '0;
		end else if (ctl.load) begin
			idx_q <= '0;
		end else if (ctl.exec) begin
			case (kind_q)
				KIND_TICK: begin
					if (!idx_last) idx_q <= idx_q + 1'b1;
				end
				KIND_INSTALL: begin
					if (free_found) begin
						used_q[free_idx]    <= 1'b1;
						running_q[free_idx] <= 1'b0;
					end
				end
				KIND_RUN: begin
					if (id_ok) running_q[id_idx] <= 1'b1;
				end
				KIND_STOP: begin
					if (id_ok) running_q[id_idx] <= 1'b0;
				end
				KIND_DELETE: begin
					if (id_ok) begin
						running_q[id_idx] <= 1'b0;
						used_q[id_idx]    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q <= cmd.kind;
			id_q   <= cmd.timer_id;
			ival_q <= cmd.interval_ticks;
			fire_q <= '0;
			ok_q   <= 1'b0;
			slot_q <= '0;
		end else if (ctl.exec) begin
			case (kind_q)
				KIND_TICK: begin
					if (used_q[idx_q] && running_q[idx_q]) begin
						if (hit) begin
							count_q[idx_q] <= '0;
							fire_q[idx_q]  <= 1'b1;
						end else begin
							count_q[idx_q] <= cnt_inc;
						end
					end
				end
				KIND_INSTALL: begin
					if (free_found) begin
						period_q[free_idx] <= ival_q;
						count_q[free_idx]  <= '0;
						ok_q               <= 1'b1;
						slot_q             <= free_idx;
					end
				end
				KIND_STOP: begin
					if (id_ok) count_q[id_idx] <= '0;
				end
				default: ;
			endcase
		end
	end

	assign slot_ext         = SW'(slot_q);
	assign rsp.fired_mask   = fire_q[7:0];
	assign rsp.install_ok   = ok_q;
	assign rsp.install_slot = slot_ext[2:0];

endmodule

// ===== design/ptb_checker.sv =====
// ----------------------------------------------------------------------------
// ptb_port_assert
// Port-level checks of the periodic timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptb_port_assert (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cmd_valid,
	input logic                   cmd_stall,
	input ptb_pkg::ptb_cmd_item_t cmd,
	input logic                   rsp_valid,
	input logic                   rsp_stall,
	input ptb_pkg::ptb_rsp_item_t rsp
);
	import ptb_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("cmd accepted while an item is in flight");

	a_rsp_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cmd_stall)
		else $error("cmd open while a result is pending");

	a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.install_ok |-> rsp.install_slot == 3'd0)
		else $error("install_slot nonzero without install_ok");

	a_fire_excl_install: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fired_mask != 8'd0 |-> !rsp.install_ok)
		else $error("fired mask and install result together");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled item changed");

endmodule

bind periodic_timer_bank ptb_port_assert u_ptb_port_assert (.*);
